[sv/sliding_median_height_filter_unit_macros.svh]
// Assertion macros for the sliding median height filter.
// Included by the top level; no other dependencies.
`ifndef SLIDING_MEDIAN_HEIGHT_FILTER_UNIT_MACROS_SVH
`define SLIDING_MEDIAN_HEIGHT_FILTER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SMHF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SMHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/smhf_pkg.sv]
// Shared widths, constants and cell control type for the median height filter.
// No dependencies.
`default_nettype none

package smhf_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int HEIGHT_W       = 16;
   localparam int SPEED_W        = 23;
   localparam int OFFSET_W       = 17;
   localparam int RATE_W         = 10;
   localparam int REQ_TDATA_W    = 32;
   localparam int REQ_TUSER_W    = 1;
   localparam int RSP_TDATA_W    = 56;
   localparam int WINDOW_DEFAULT = 11;

   localparam logic [RATE_W-1:0]  RATE_RESET = 10'd50;
   localparam logic [SPEED_W-1:0] SPEED_MAX  = 23'h3FFFFF;
   localparam logic [SPEED_W-1:0] SPEED_MIN  = 23'h400000;

   typedef struct packed {
      logic load;    // take a new sample into the window, restart counts
      logic fill;    // first sample: every cell takes the sample
      logic rotate;  // compare and pass the circulating value on
   } cell_ctl_type;

endpackage

`default_nettype wire

[sv/smhf_cell.sv]
// One window cell: holds a window entry and ranks it against a circulating value.
// Depends on smhf_pkg.
`default_nettype none

module smhf_cell #(
   parameter int CNT_W = 4
) (
   input  wire                           clock,
   input  wire smhf_pkg::cell_ctl_type   ctl,
   input  wire [smhf_pkg::SAMPLE_W-1:0]  fill_value,
   input  wire [smhf_pkg::SAMPLE_W-1:0]  shift_in,
   input  wire [smhf_pkg::SAMPLE_W-1:0]  circ_in,
   output logic [smhf_pkg::SAMPLE_W-1:0] value_out,
   output logic [smhf_pkg::SAMPLE_W-1:0] circ_out,
   output logic [CNT_W-1:0]              lt_count,
   output logic [CNT_W-1:0]              le_count
);
   import smhf_pkg::*;

   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [SAMPLE_W-1:0] circ_ff, circ_in_nxt;
   logic [CNT_W-1:0]    lt_ff, lt_in;
   logic [CNT_W-1:0]    le_ff, le_in;

   always_comb begin
      value_in    = value_ff;
      circ_in_nxt = circ_ff;
      lt_in       = lt_ff;
      le_in       = le_ff;
      if (ctl.load) begin
         value_in    = ctl.fill ? fill_value : shift_in;
         circ_in_nxt = value_in;
         lt_in       = '0;
         le_in       = '0;
      end else if (ctl.rotate) begin
         circ_in_nxt = circ_in;
         lt_in       = lt_ff + CNT_W'(circ_ff < value_ff);
         le_in       = le_ff + CNT_W'(circ_ff <= value_ff);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      circ_ff  <= circ_in_nxt;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
   end

   assign value_out = value_ff;
   assign circ_out  = circ_ff;
   assign lt_count  = lt_ff;
   assign le_count  = le_ff;

endmodule

`default_nettype wire

[sv/sliding_median_height_filter_unit.sv]
// Sliding median height filter: top level, a ring of WINDOW rank cells plus control.
// An accepted request walks the ring in S_RUN, then waits in S_DONE for the response register.
// One transaction at a time: a new request is taken only in S_IDLE, after the ring rotation walk.
// Reset (synchronous, active high): rate 50, not primed, previous sample and offset 0.
// Depends on smhf_pkg, smhf_cell and sliding_median_height_filter_unit_macros.svh.
`default_nettype none
`include "sliding_median_height_filter_unit_macros.svh"

module sliding_median_height_filter_unit #(
   parameter int WINDOW = smhf_pkg::WINDOW_DEFAULT   // 3 .. 31
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [smhf_pkg::REQ_TDATA_W-1:0]    req_tdata,  // range_mm[11:0], height_mm[27:12]
   input  wire [smhf_pkg::REQ_TUSER_W-1:0]    req_tuser,  // source_is_ultra[0]
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [smhf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // median_mm[11:0], speed_mm_s[34:12],
                                                          // offset_mm[51:35], zero[55:52]
   // configuration: sample_rate_hz
   input  wire                                csr_wr_en,
   input  wire [smhf_pkg::RATE_W-1:0]         csr_wr_data
);
   import smhf_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W-1:0] MID_RANK  = CNT_W'(WINDOW / 2);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   // Unpack the request transaction.
   logic [SAMPLE_W-1:0] req_range;
   logic [HEIGHT_W-1:0] req_height;
   logic                req_ultra;
   assign req_range  = req_tdata[SAMPLE_W-1:0];
   assign req_height = req_tdata[SAMPLE_W+HEIGHT_W-1:SAMPLE_W];
   assign req_ultra  = req_tuser[0];

   // Control and registered outputs.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic                primed_ff, primed_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [OFFSET_W-1:0] held_ff, held_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Per-item payload.
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                ultra_ff, ultra_in;
   logic [SAMPLE_W-1:0] out_median_ff, out_median_in;
   logic [SPEED_W-1:0]  out_speed_ff, out_speed_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;

   logic                req_accept;
   logic                out_free;
   logic                finish;
   cell_ctl_type        cell_ctl;

   // Cell ring wiring.
   logic [SAMPLE_W-1:0] value_w [WINDOW];
   logic [SAMPLE_W-1:0] circ_w  [WINDOW];
   logic [CNT_W-1:0]    lt_w    [WINDOW];
   logic [CNT_W-1:0]    le_w    [WINDOW];
   logic [WINDOW-1:0]   median_sel;
   logic [SAMPLE_W-1:0] median;

   // Speed arithmetic.
   logic signed [SAMPLE_W:0]          diff;
   logic signed [SAMPLE_W+RATE_W+1:0] product;
   logic [OFFSET_W-1:0]               offset_new;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == S_DONE) && out_free;

   assign cell_ctl.load   = req_accept;
   assign cell_ctl.fill   = !primed_ff;
   assign cell_ctl.rotate = (state_ff == S_RUN);

   // The window is a shift chain: the new sample enters cell 0 and the oldest
   // drops out of the far end, which keeps the same set of entries as a
   // circular buffer. During the walk the circulating values go around the ring.
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
      logic [SAMPLE_W-1:0] shift_src;
      if (i == 0) begin : g_head
         assign shift_src = req_range;
      end else begin : g_body
         assign shift_src = value_w[i-1];
      end

      smhf_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .fill_value(req_range),
         .shift_in  (shift_src),
         .circ_in   (circ_w[PREV]),
         .value_out (value_w[i]),
         .circ_out  (circ_w[i]),
         .lt_count  (lt_w[i]),
         .le_count  (le_w[i])
      );

      // A cell holds the median when fewer than MID_RANK+1 entries are below it
      // and more than MID_RANK entries are at or below it.
      assign median_sel[i] = (lt_w[i] <= MID_RANK) && (le_w[i] > MID_RANK);
   end

   // All selected cells carry the same value, so OR them together.
   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW; i++) begin
         median = median | (median_sel[i] ? value_w[i] : '0);
      end
   end

   // Speed: (range - previous) * rate, clamp to the output range.
   assign diff    = $signed({1'b0, req_range}) - $signed({1'b0, prev_ff});
   assign product = diff * $signed({1'b0, rate_ff});

   always_comb begin
      if (product[SPEED_W] != product[SPEED_W-1]) begin
         speed_in = product[SPEED_W] ? SPEED_MIN : SPEED_MAX;
      end else begin
         speed_in = product[SPEED_W-1:0];
      end
   end

   // Offset: reload height minus median unless height follows this sensor.
   assign offset_new = {height_ff[HEIGHT_W-1], height_ff} - {{(OFFSET_W-SAMPLE_W){1'b0}}, median};

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      primed_in     = primed_ff;
      prev_in       = prev_ff;
      held_in       = held_ff;
      rate_in       = csr_wr_en ? csr_wr_data : rate_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      height_in     = height_ff;
      ultra_in      = ultra_ff;
      out_median_in = out_median_ff;
      out_speed_in  = out_speed_ff;
      out_offset_in = out_offset_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in  = S_RUN;
               step_in   = '0;
               primed_in = 1'b1;
               prev_in   = req_range;
               height_in = req_height;
               ultra_in  = req_ultra;
            end
         end
         S_RUN: begin
            step_in = step_ff + CNT_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold the result until the response register frees up.
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               out_median_in = median;
               out_speed_in  = speed_ff;
               out_offset_in = ultra_ff ? held_ff : offset_new;
               held_in       = out_offset_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         primed_ff    <= 1'b0;
         prev_ff      <= '0;
         held_ff      <= '0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         primed_ff    <= primed_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         speed_ff <= speed_in;
      end
      height_ff     <= height_in;
      ultra_ff      <= ultra_in;
      out_median_ff <= out_median_in;
      out_speed_ff  <= out_speed_in;
      out_offset_ff <= out_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-SAMPLE_W-SPEED_W-OFFSET_W){1'b0}},
                        out_offset_ff, out_speed_ff, out_median_ff};

   // One item at a time: an accepted transaction closes the request side.
   `SMHF_ASSERT_NEXT(a_one_in_flight, clock, reset, req_accept, !req_tready,
      "request accepted while an item is still in flight")

   // After the full walk the median rank must be found in at least one cell.
   `SMHF_ASSERT_NOW(a_median_found, clock, reset, state_ff == S_DONE, |median_sel,
      "no cell holds the median rank")

   // A finished item shows up as a valid response and frees the request side.
   `SMHF_ASSERT_NEXT(a_finish_delivers, clock, reset, finish,
      rsp_valid_ff && (state_ff == S_IDLE),
      "finished item did not reach the response register")

endmodule

`default_nettype wire
